FILE: hdl/ramr_pkg.sv
// ----------------------------------------------------------------------------
// ramr_pkg: shared definitions for the rational add/multiply/reduce core
// Widths and the queue depth shared by the parts of the core.
// ----------------------------------------------------------------------------
package ramr_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned NumWidth     = 33;
  localparam int unsigned DenWidth     = 32;
  localparam int unsigned QueueDepth   = 2;

endpackage

FILE: hdl/ramr_front.sv
// ----------------------------------------------------------------------------
// ramr_front: operand intake
// Turns the operands into sign/magnitude form, forms the exact raw numerator
// and denominator in registered steps and hands them on as one beat.
// ----------------------------------------------------------------------------
module ramr_front #(
  parameter int unsigned OW = ramr_pkg::OperandWidth,
  parameter int unsigned MW = 2 * OW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic          op_i,
  input  logic [OW-1:0] a_num_i,
  input  logic [OW-1:0] a_den_i,
  input  logic [OW-1:0] b_num_i,
  input  logic [OW-1:0] b_den_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic          p_neg_o,
  output logic [MW-1:0] p_mag_o,
  output logic          q_neg_o,
  output logic [MW-1:0] q_mag_o
);
  localparam int unsigned PW = 2 * OW;

  // Stage 0 holds operands, stage 1 the products, stage 2 the raw pair.
  logic [1:0]    st_q, st_d;
  logic          op_q;
  logic [OW:0]   an_q, ad_q, bn_q, bd_q; // sign at top, magnitude below
  logic [PW-1:0] m0_q, m1_q, m2_q;
  logic          s0_q, s1_q, s2_q;
  logic          pn_q, qn_q;
  logic [MW-1:0] pm_q, qm_q;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  function automatic logic [OW:0] to_sm(input logic [OW-1:0] v);
    logic [OW-1:0] m;
    m = v[OW-1] ? (~v + 1'b1) : v;
    return {v[OW-1], m};
  endfunction

  assign full_o  = (st_q != StIdle);
  assign valid_o = (st_q == StOut);
  assign p_neg_o = pn_q;
  assign p_mag_o = pm_q;
  assign q_neg_o = qn_q;
  assign q_mag_o = qm_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (push_i) st_d = StMul;
      StMul:  st_d = StAdd;
      StAdd:  st_d = StOut;
      StOut:  if (ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && push_i) begin
      op_q <= op_i;
      an_q <= to_sm(a_num_i);
      ad_q <= to_sm(a_den_i);
      bn_q <= to_sm(b_num_i);
      bd_q <= to_sm(b_den_i);
    end
    if (st_q == StMul) begin
      m0_q <= PW'(an_q[OW-1:0]) * PW'(op_q ? bn_q[OW-1:0] : bd_q[OW-1:0]);
      s0_q <= an_q[OW] ^ (op_q ? bn_q[OW] : bd_q[OW]);
      m1_q <= PW'(bn_q[OW-1:0]) * PW'(ad_q[OW-1:0]);
      s1_q <= bn_q[OW] ^ ad_q[OW];
      m2_q <= PW'(ad_q[OW-1:0]) * PW'(bd_q[OW-1:0]);
      s2_q <= ad_q[OW] ^ bd_q[OW];
    end
    if (st_q == StAdd) begin
      qm_q <= MW'(m2_q);
      qn_q <= s2_q && (m2_q != '0);
      if (op_q || m1_q == '0) begin
        pm_q <= MW'(m0_q);
        pn_q <= s0_q && (m0_q != '0);
      end else if (m0_q == '0) begin
        pm_q <= MW'(m1_q);
        pn_q <= s1_q;
      end else if (s0_q == s1_q) begin
        pm_q <= MW'(m0_q) + MW'(m1_q);
        pn_q <= s0_q;
      end else if (m0_q >= m1_q) begin
        pm_q <= MW'(m0_q - m1_q);
        pn_q <= s0_q && (m0_q != m1_q);
      end else begin
        pm_q <= MW'(m1_q - m0_q);
        pn_q <= s1_q;
      end
    end
  end
endmodule

FILE: hdl/ramr_queue.sv
// ----------------------------------------------------------------------------
// ramr_queue: small register queue between front and back parts
// Holds raw pairs so that intake and reduction stall independently.
// ----------------------------------------------------------------------------
module ramr_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned Depth = ramr_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [W-1:0]  mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          wr, rd;

  assign wr_ready_o = (cnt_q != CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

FILE: hdl/ramr_back.sv
// ----------------------------------------------------------------------------
// ramr_back: gcd reduction
// One shared restoring divider, one quotient bit per cycle, runs Euclid's
// remainder steps, then two exact divisions by the gcd; zero q flags an error.
// ----------------------------------------------------------------------------
module ramr_back #(
  parameter int unsigned OW = ramr_pkg::OperandWidth,
  parameter int unsigned MW = 2 * OW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic          p_neg_i,
  input  logic [MW-1:0] p_mag_i,
  input  logic          q_neg_i,
  input  logic [MW-1:0] q_mag_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [ramr_pkg::NumWidth-1:0] res_num_o,
  output logic [ramr_pkg::DenWidth-1:0] res_den_o,
  output logic          div_error_o
);
  import ramr_pkg::*;

  localparam int unsigned BW = $clog2(MW + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StGcd  = 3'd2;
  localparam logic [2:0] StNum  = 3'd3;
  localparam logic [2:0] StDen  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  localparam logic [1:0] PhGcd = 2'd0;
  localparam logic [1:0] PhNum = 2'd1;
  localparam logic [1:0] PhDen = 2'd2;

  logic [2:0]    st_q;
  logic [1:0]    ph_q;       // what the running division is for
  logic          pn_q, qn_q, odd_q;
  logic [MW-1:0] pm_q, qm_q, y_q, nq_q;
  // Divider state.
  logic [MW-1:0] dvd_q, rem_q;
  logic [BW-1:0] bit_q;
  logic [MW:0]   trial;
  logic [MW-1:0] rem_n, dvd_n;
  logic          g_neg, rn_neg, rd_neg;
  logic [NumWidth-1:0] num_q;
  logic [DenWidth-1:0] den_q;
  logic          err_q;

  assign trial   = {rem_q, dvd_q[MW-1]};
  assign rem_n   = (trial >= {1'b0, y_q}) ? MW'(trial - {1'b0, y_q}) : trial[MW-1:0];
  assign dvd_n   = {dvd_q[MW-2:0], (trial >= {1'b0, y_q})};
  assign g_neg   = odd_q ? pn_q : qn_q;
  assign rn_neg  = (nq_q != '0) && (pn_q != g_neg);
  assign rd_neg  = (qn_q != g_neg);

  assign ready_o     = (st_q == StIdle);
  assign empty_o     = (st_q != StOut);
  assign res_num_o   = num_q;
  assign res_den_o   = den_q;
  assign div_error_o = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: if (valid_i) st_q <= (q_mag_i == '0) ? StOut : StDiv;
        StDiv:  if (bit_q == BW'(1)) st_q <= (ph_q == PhGcd) ? StGcd
                                           : (ph_q == PhNum) ? StNum : StDen;
        StGcd:  st_q <= StDiv;
        StNum:  st_q <= StDiv;
        StDen:  st_q <= StOut;
        StOut:  if (pop_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (valid_i) begin
        pn_q  <= p_neg_i;
        pm_q  <= p_mag_i;
        qn_q  <= q_neg_i;
        qm_q  <= q_mag_i;
        y_q   <= q_mag_i;
        dvd_q <= p_mag_i;
        rem_q <= '0;
        bit_q <= BW'(MW);
        odd_q <= 1'b0;
        ph_q  <= PhGcd;
        err_q <= (q_mag_i == '0);
        num_q <= '0;
        den_q <= '0;
      end
      StDiv: begin
        rem_q <= rem_n;
        dvd_q <= dvd_n;
        bit_q <= bit_q - 1'b1;
      end
      StGcd: begin
        bit_q <= BW'(MW);
        if (rem_q == '0) begin
          // y now holds the gcd magnitude; divide the numerator by it.
          ph_q  <= PhNum;
          dvd_q <= pm_q;
          rem_q <= '0;
        end else begin
          y_q   <= rem_q;
          dvd_q <= y_q;
          rem_q <= '0;
          odd_q <= ~odd_q;
        end
      end
      StNum: begin
        nq_q  <= dvd_q;
        ph_q  <= PhDen;
        dvd_q <= qm_q;
        rem_q <= '0;
        bit_q <= BW'(MW);
      end
      StDen: begin
        num_q <= rn_neg ? NumWidth'(~nq_q + 1'b1) : NumWidth'(nq_q);
        den_q <= rd_neg ? DenWidth'(~dvd_q + 1'b1) : DenWidth'(dvd_q);
      end
      default: ;
    endcase
  end
endmodule

FILE: hdl/rational_add_mul_reduce_core.sv
// ----------------------------------------------------------------------------
// rational_add_mul_reduce_core: rational add/multiply with gcd reduction
// Front part forms the exact raw fraction, back part reduces it by Euclid.
// ----------------------------------------------------------------------------
// An item passes operand capture, products and add steps in the front part;
// in the back part it takes one (2*OPERAND_WIDTH+1)-bit restoring division
// for each Euclid remainder step, then two more such divisions for the
// reduced numerator and denominator. The single shared divider sets the
// rate; a two-entry queue lets the front take the next item while the back
// part is reducing.
module rational_add_mul_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = ramr_pkg::OperandWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          op_i,
  input  logic [OPERAND_WIDTH-1:0]      a_num_i,
  input  logic [OPERAND_WIDTH-1:0]      a_den_i,
  input  logic [OPERAND_WIDTH-1:0]      b_num_i,
  input  logic [OPERAND_WIDTH-1:0]      b_den_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ramr_pkg::NumWidth-1:0] res_num_o,
  output logic [ramr_pkg::DenWidth-1:0] res_den_o,
  output logic                          div_error_o
);
  import ramr_pkg::*;

  localparam int unsigned MW = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned QW = 2 * MW + 2;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic          p_neg, q_neg;
  logic [MW-1:0] p_mag, q_mag;
  logic [QW-1:0] q_out;

  ramr_front #(.OW(OPERAND_WIDTH), .MW(MW)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .op_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .valid_o(f_valid), .ready_i(f_ready),
    .p_neg_o(p_neg), .p_mag_o(p_mag), .q_neg_o(q_neg), .q_mag_o(q_mag)
  );

  ramr_queue #(.W(QW), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i({p_neg, p_mag, q_neg, q_mag}),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(q_out)
  );

  ramr_back #(.OW(OPERAND_WIDTH), .MW(MW)) u_back (
    .clk_i, .rst_ni, .valid_i(b_valid), .ready_o(b_ready),
    .p_neg_i(q_out[QW-1]), .p_mag_i(q_out[QW-2:MW+1]),
    .q_neg_i(q_out[MW]), .q_mag_i(q_out[MW-1:0]),
    .empty_o(empty), .pop_i(pop),
    .res_num_o, .res_den_o, .div_error_o
  );
endmodule
